// ===== hw/rtl/gzip_member_header_parser_defines.svh =====
// Assertion helpers for the checker file.
`ifndef GZIP_MEMBER_HEADER_PARSER_DEFINES_SVH
`define GZIP_MEMBER_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define GZMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GZMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gzmh_pkg.sv =====
package gzmh_pkg;

    localparam logic [7:0] MAGIC_FIRST    = 8'h1F;
    localparam logic [7:0] MAGIC_SECOND   = 8'h8B;
    localparam logic [7:0] METHOD_DEFLATE = 8'd8;
    localparam logic [7:0] FLAG_FHCRC     = 8'h02;
    localparam logic [7:0] FLAG_FEXTRA    = 8'h04;
    localparam logic [7:0] FLAG_FNAME     = 8'h08;
    localparam logic [7:0] FLAG_FCOMMENT  = 8'h10;
    localparam logic [7:0] NUL_BYTE       = 8'h00;

    typedef enum logic [3:0] {
        PH_ID1     = 4'd0,
        PH_ID2     = 4'd1,
        PH_CM      = 4'd2,
        PH_FLG     = 4'd3,
        PH_MTIME   = 4'd4,
        PH_XFL     = 4'd5,
        PH_OS      = 4'd6,
        PH_XLEN    = 4'd7,
        PH_EXTRA   = 4'd8,
        PH_NAME    = 4'd9,
        PH_COMMENT = 4'd10,
        PH_HCRC    = 4'd11,
        PH_BODY    = 4'd12,
        PH_ERROR   = 4'd13
    } phase_t;

    typedef enum logic [3:0] {
        KIND_MAGIC        = 4'd0,
        KIND_METHOD       = 4'd1,
        KIND_FLAGS        = 4'd2,
        KIND_MTIME        = 4'd3,
        KIND_XFL          = 4'd4,
        KIND_OS           = 4'd5,
        KIND_XLEN         = 4'd6,
        KIND_EXTRA        = 4'd7,
        KIND_NAME         = 4'd8,
        KIND_NAME_END     = 4'd9,
        KIND_COMMENT      = 4'd10,
        KIND_COMMENT_END  = 4'd11,
        KIND_HCRC         = 4'd12,
        KIND_BODY         = 4'd13,
        KIND_ERROR        = 4'd14,
        KIND_IGNORED      = 4'd15
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_word_t;

    typedef struct packed {
        kind_t       field_kind;
        logic [7:0]  byte_out;
        logic        header_done;
        logic [31:0] mtime_out;
        logic [7:0]  flags_out;
        logic [15:0] extra_length_out;
        logic        error_out;
    } out_word_t;

    // first optional section at or after 'from' that the flags enable, else PH_BODY
    function automatic phase_t next_section(phase_t from, logic [7:0] flags);
        phase_t nxt;
        if (from <= PH_XLEN && (flags & FLAG_FEXTRA) != 8'h00) begin
            nxt = PH_XLEN;
        end else if (from <= PH_NAME && (flags & FLAG_FNAME) != 8'h00) begin
            nxt = PH_NAME;
        end else if (from <= PH_COMMENT && (flags & FLAG_FCOMMENT) != 8'h00) begin
            nxt = PH_COMMENT;
        end else if (from <= PH_HCRC && (flags & FLAG_FHCRC) != 8'h00) begin
            nxt = PH_HCRC;
        end else begin
            nxt = PH_BODY;
        end
        return nxt;
    endfunction

endpackage

// ===== hw/rtl/gzmh_in_stage.sv =====
module gzmh_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gzmh_pkg::in_word_t s_data,
    input  logic               advance,
    output logic               in_valid,
    output gzmh_pkg::in_word_t in_data
);

    logic               valid_reg;
    logic               valid_next;
    gzmh_pkg::in_word_t data_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign in_valid = valid_reg;
    assign in_data  = data_reg;

endmodule

// ===== hw/rtl/gzmh_parser.sv =====
module gzmh_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  gzmh_pkg::in_word_t  in_data,
    output gzmh_pkg::out_word_t result
);

    gzmh_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [15:0]      count_reg, count_next, count_cur, count_inc;
    logic [7:0]       flags_reg, flags_next, flags_cur;
    logic [31:0]      mtime_reg, mtime_next, mtime_cur;
    logic [15:0]      xlen_reg, xlen_next, xlen_cur, xlen_full;
    logic             err_reg, err_next, err_cur;
    logic [7:0]       b;
    gzmh_pkg::kind_t  kind;

    assign b = in_data.data_byte;

    // restart behaves as a reset applied just before this word
    always_comb begin
        if (in_data.restart) begin
            phase_cur = gzmh_pkg::PH_ID1;
            count_cur = 16'd0;
            flags_cur = 8'd0;
            mtime_cur = 32'd0;
            xlen_cur  = 16'd0;
            err_cur   = 1'b0;
        end else begin
            phase_cur = phase_reg;
            count_cur = count_reg;
            flags_cur = flags_reg;
            mtime_cur = mtime_reg;
            xlen_cur  = xlen_reg;
            err_cur   = err_reg;
        end
    end

    assign count_inc = count_cur + 16'd1;
    assign xlen_full = xlen_cur | {b, 8'h00};

    always_comb begin
        phase_next = phase_cur;
        count_next = count_cur;
        flags_next = flags_cur;
        mtime_next = mtime_cur;
        xlen_next  = xlen_cur;
        err_next   = err_cur;
        case (phase_cur)
            gzmh_pkg::PH_ID1: begin
                if (b == gzmh_pkg::MAGIC_FIRST) begin
                    phase_next = gzmh_pkg::PH_ID2;
                end else begin
                    err_next   = 1'b1;
                    phase_next = gzmh_pkg::PH_ERROR;
                end
            end
            gzmh_pkg::PH_ID2: begin
                if (b == gzmh_pkg::MAGIC_SECOND) begin
                    phase_next = gzmh_pkg::PH_CM;
                end else begin
                    err_next   = 1'b1;
                    phase_next = gzmh_pkg::PH_ERROR;
                end
            end
            gzmh_pkg::PH_CM: begin
                if (b == gzmh_pkg::METHOD_DEFLATE) begin
                    phase_next = gzmh_pkg::PH_FLG;
                end else begin
                    err_next   = 1'b1;
                    phase_next = gzmh_pkg::PH_ERROR;
                end
            end
            gzmh_pkg::PH_FLG: begin
                flags_next = b;
                count_next = 16'd0;
                phase_next = gzmh_pkg::PH_MTIME;
            end
            gzmh_pkg::PH_MTIME: begin
                mtime_next = mtime_cur | ({24'd0, b} << {count_cur[1:0], 3'b000});
                if (count_cur >= 16'd3) begin
                    count_next = 16'd0;
                    phase_next = gzmh_pkg::PH_XFL;
                end else begin
                    count_next = count_inc;
                end
            end
            gzmh_pkg::PH_XFL: begin
                phase_next = gzmh_pkg::PH_OS;
            end
            gzmh_pkg::PH_OS: begin
                count_next = 16'd0;
                phase_next = gzmh_pkg::next_section(gzmh_pkg::PH_XLEN, flags_cur);
            end
            gzmh_pkg::PH_XLEN: begin
                if (count_cur == 16'd0) begin
                    xlen_next  = {8'd0, b};
                    count_next = 16'd1;
                end else begin
                    xlen_next  = xlen_full;
                    count_next = 16'd0;
                    phase_next = (xlen_full == 16'd0)
                        ? gzmh_pkg::next_section(gzmh_pkg::PH_NAME, flags_cur)
                        : gzmh_pkg::PH_EXTRA;
                end
            end
            gzmh_pkg::PH_EXTRA: begin
                count_next = count_inc;
                if (count_inc >= xlen_cur) begin
                    count_next = 16'd0;
                    phase_next = gzmh_pkg::next_section(gzmh_pkg::PH_NAME, flags_cur);
                end
            end
            gzmh_pkg::PH_NAME: begin
                if (b == gzmh_pkg::NUL_BYTE) begin
                    phase_next = gzmh_pkg::next_section(gzmh_pkg::PH_COMMENT, flags_cur);
                end
            end
            gzmh_pkg::PH_COMMENT: begin
                if (b == gzmh_pkg::NUL_BYTE) begin
                    phase_next = gzmh_pkg::next_section(gzmh_pkg::PH_HCRC, flags_cur);
                end
            end
            gzmh_pkg::PH_HCRC: begin
                if (count_cur == 16'd0) begin
                    count_next = 16'd1;
                end else begin
                    count_next = 16'd0;
                    phase_next = gzmh_pkg::PH_BODY;
                end
            end
            gzmh_pkg::PH_BODY: begin
                phase_next = gzmh_pkg::PH_BODY;
            end
            default: begin
                phase_next = gzmh_pkg::PH_ERROR;
            end
        endcase
    end

    always_comb begin
        case (phase_cur)
            gzmh_pkg::PH_ID1, gzmh_pkg::PH_ID2: begin
                kind = (phase_next == gzmh_pkg::PH_ERROR) ? gzmh_pkg::KIND_ERROR
                                                          : gzmh_pkg::KIND_MAGIC;
            end
            gzmh_pkg::PH_CM: begin
                kind = (phase_next == gzmh_pkg::PH_ERROR) ? gzmh_pkg::KIND_ERROR
                                                          : gzmh_pkg::KIND_METHOD;
            end
            gzmh_pkg::PH_FLG:     kind = gzmh_pkg::KIND_FLAGS;
            gzmh_pkg::PH_MTIME:   kind = gzmh_pkg::KIND_MTIME;
            gzmh_pkg::PH_XFL:     kind = gzmh_pkg::KIND_XFL;
            gzmh_pkg::PH_OS:      kind = gzmh_pkg::KIND_OS;
            gzmh_pkg::PH_XLEN:    kind = gzmh_pkg::KIND_XLEN;
            gzmh_pkg::PH_EXTRA:   kind = gzmh_pkg::KIND_EXTRA;
            gzmh_pkg::PH_NAME: begin
                kind = (b == gzmh_pkg::NUL_BYTE) ? gzmh_pkg::KIND_NAME_END
                                                 : gzmh_pkg::KIND_NAME;
            end
            gzmh_pkg::PH_COMMENT: begin
                kind = (b == gzmh_pkg::NUL_BYTE) ? gzmh_pkg::KIND_COMMENT_END
                                                 : gzmh_pkg::KIND_COMMENT;
            end
            gzmh_pkg::PH_HCRC:    kind = gzmh_pkg::KIND_HCRC;
            gzmh_pkg::PH_BODY:    kind = gzmh_pkg::KIND_BODY;
            default:              kind = gzmh_pkg::KIND_IGNORED;
        endcase
    end

    always_comb begin
        result.field_kind       = kind;
        result.byte_out         = b;
        result.header_done      = (phase_next == gzmh_pkg::PH_BODY)
                               && (phase_cur != gzmh_pkg::PH_BODY);
        result.mtime_out        = mtime_next;
        result.flags_out        = flags_next;
        result.extra_length_out = xlen_next;
        result.error_out        = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= gzmh_pkg::PH_ID1;
            count_reg <= 16'd0;
            flags_reg <= 8'd0;
            mtime_reg <= 32'd0;
            xlen_reg  <= 16'd0;
            err_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            flags_reg <= flags_next;
            mtime_reg <= mtime_next;
            xlen_reg  <= xlen_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== hw/rtl/gzmh_out_stage.sv =====
module gzmh_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  gzmh_pkg::out_word_t load_data,
    output logic                advance,
    output logic                m_valid,
    input  logic                m_ready,
    output gzmh_pkg::out_word_t m_data
);

    logic                valid_reg;
    logic                valid_next;
    gzmh_pkg::out_word_t data_reg;

    // result register is free when empty or being drained this cycle
    assign advance    = in_valid && (!valid_reg || m_ready);
    assign valid_next = advance || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== hw/rtl/gzip_member_header_parser.sv =====
// gzip member header parser. Takes one stream byte per word and returns one
// classified word per byte, in order: magic, method, flags, mtime, xfl, os,
// then the optional extra field, name, comment and header CRC as the flags
// select, then body bytes until restart. Bad magic or method sets a sticky
// error that only reset or a restart word clears, and later bytes are classed
// as ignored. Throughput is one word per clock while the output is not
// stalled. The word sits in the input register while the combinational parse
// step runs; the result register takes it once free. Both sides are valid/ready;
// the input side accepts while a result waits, until both registers are full.
module gzip_member_header_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gzmh_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gzmh_pkg::out_word_t m_data
);

    logic                advance;
    logic                in_valid;
    gzmh_pkg::in_word_t  in_data;
    gzmh_pkg::out_word_t result;

    gzmh_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .advance  (advance),
        .in_valid (in_valid),
        .in_data  (in_data)
    );

    gzmh_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_data (in_data),
        .result  (result)
    );

    gzmh_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .load_data (result),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== hw/rtl/gzmh_checker.sv =====
`include "gzip_member_header_parser_defines.svh"

module gzmh_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input gzmh_pkg::out_word_t m_data
);

    logic done_kind_ok;
    logic err_kind;

    // header can only finish on one of these kinds
    assign done_kind_ok = (m_data.field_kind == gzmh_pkg::KIND_OS)
                       || (m_data.field_kind == gzmh_pkg::KIND_XLEN)
                       || (m_data.field_kind == gzmh_pkg::KIND_EXTRA)
                       || (m_data.field_kind == gzmh_pkg::KIND_NAME_END)
                       || (m_data.field_kind == gzmh_pkg::KIND_COMMENT_END)
                       || (m_data.field_kind == gzmh_pkg::KIND_HCRC);
    assign err_kind = (m_data.field_kind == gzmh_pkg::KIND_ERROR)
                   || (m_data.field_kind == gzmh_pkg::KIND_IGNORED);

    `GZMH_ASSERT_NOW(a_done_kind, m_valid && m_data.header_done, done_kind_ok, "bad done kind")
    `GZMH_ASSERT_NOW(a_err_flag, m_valid && err_kind, m_data.error_out, "error flag low")
    `GZMH_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready, "input stalled while empty")
    `GZMH_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "word changed")

endmodule

bind gzip_member_header_parser gzmh_checker u_gzmh_checker (.*);
